>>> rtl/core/rket_pkg.sv
// Shared types, constants and the key code table of the remote key event translator.
package rket_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam logic [7:0]  HEADER_CODE  = 8'h14;
    localparam logic [7:0]  TRAILER_CODE = 8'hf0;
    localparam logic [3:0]  PACKET_LEN   = 4'd4;
    localparam logic [10:0] TICKS_RESET  = 11'd100;

    // configuration register indexes
    localparam logic [1:0] REG_TICKS = 2'd0;

    // event kinds
    localparam logic EV_KEY    = 1'b0;
    localparam logic EV_MOTION = 1'b1;

    // motion axes
    localparam logic [5:0] AXIS_X = 6'd0;
    localparam logic [5:0] AXIS_Y = 6'd1;

    typedef enum logic [1:0] {
        K_BUTTON = 2'd0,
        K_MOVE   = 2'd1,
        K_DIAG   = 2'd2,
        K_FILT   = 2'd3
    } row_kind_t;

    typedef struct packed {
        logic              hit;
        logic [5:0]        row;
        row_kind_t         kind;
        logic signed [1:0] sx;
        logic signed [1:0] sy;
    } row_info_t;

    typedef struct packed {
        logic       transfer_error;
        logic [3:0] packet_length;
        logic [7:0] header_byte;
        logic [7:0] key_byte_a;
        logic [7:0] key_byte_b;
        logic [7:0] trailer_byte;
        logic [31:0] time_now;
    } packet_t;

    typedef struct packed {
        logic              event_kind;
        logic [5:0]        event_code;
        logic signed [4:0] event_value;
        logic              last_event;
    } event_t;

    typedef struct packed {
        logic       frame_ok;
        logic       same;
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } xlate_res_t;

    function automatic row_info_t mk_row(input logic [5:0] row, input row_kind_t kind,
                                         input logic signed [1:0] sx,
                                         input logic signed [1:0] sy);
        row_info_t r;
        r.hit  = 1'b1;
        r.row  = row;
        r.kind = kind;
        r.sx   = sx;
        r.sy   = sy;
        return r;
    endfunction

    function automatic row_info_t filt_row(input logic [5:0] row);
        return mk_row(row, K_FILT, 2'sd0, 2'sd0);
    endfunction

    function automatic row_info_t row_lookup(input logic [15:0] key);
        row_info_t r;
        r = '0;
        unique case (key)
            16'h3d78: r = mk_row(6'd0,  K_BUTTON,  2'sd1,  2'sd0);
            16'h3e79: r = mk_row(6'd1,  K_BUTTON,  2'sd0,  2'sd0);
            16'h417c: r = mk_row(6'd2,  K_BUTTON,  2'sd1,  2'sd0);
            16'h427d: r = mk_row(6'd3,  K_BUTTON,  2'sd0,  2'sd0);
            16'h3570: r = mk_row(6'd4,  K_MOVE,   -2'sd1,  2'sd0);
            16'h3671: r = mk_row(6'd5,  K_MOVE,    2'sd1,  2'sd0);
            16'h3772: r = mk_row(6'd6,  K_MOVE,    2'sd0, -2'sd1);
            16'h3873: r = mk_row(6'd7,  K_MOVE,    2'sd0,  2'sd1);
            16'h3974: r = mk_row(6'd8,  K_DIAG,   -2'sd1, -2'sd1);
            16'h3a75: r = mk_row(6'd9,  K_DIAG,    2'sd1, -2'sd1);
            16'h3c77: r = mk_row(6'd10, K_DIAG,   -2'sd1,  2'sd1);
            16'h3b76: r = mk_row(6'd11, K_DIAG,    2'sd1,  2'sd1);
            16'he21d: r = filt_row(6'd12);
            16'he41f: r = filt_row(6'd13);
            16'he722: r = filt_row(6'd14);
            16'hdf1a: r = filt_row(6'd15);
            16'he31e: r = filt_row(6'd16);
            16'hd20d: r = filt_row(6'd17);
            16'hd30e: r = filt_row(6'd18);
            16'hd40f: r = filt_row(6'd19);
            16'hd510: r = filt_row(6'd20);
            16'hd611: r = filt_row(6'd21);
            16'hd712: r = filt_row(6'd22);
            16'hd813: r = filt_row(6'd23);
            16'hd914: r = filt_row(6'd24);
            16'hda15: r = filt_row(6'd25);
            16'hdc17: r = filt_row(6'd26);
            16'hdd18: r = filt_row(6'd27);
            16'hc500: r = filt_row(6'd28);
            16'hc601: r = filt_row(6'd29);
            16'hde19: r = filt_row(6'd30);
            16'he01b: r = filt_row(6'd31);
            16'he621: r = filt_row(6'd32);
            16'he823: r = filt_row(6'd33);
            16'hdb16: r = filt_row(6'd34);
            16'hc702: r = filt_row(6'd35);
            16'hc803: r = filt_row(6'd36);
            16'hc904: r = filt_row(6'd37);
            16'hca05: r = filt_row(6'd38);
            16'hcb06: r = filt_row(6'd39);
            16'hcc07: r = filt_row(6'd40);
            16'he11c: r = filt_row(6'd41);
            16'hce09: r = filt_row(6'd42);
            16'hcd08: r = filt_row(6'd43);
            16'hcf0a: r = filt_row(6'd44);
            16'hd10c: r = filt_row(6'd45);
            16'hd00b: r = filt_row(6'd46);
            16'hec27: r = filt_row(6'd47);
            16'hea25: r = filt_row(6'd48);
            16'he924: r = filt_row(6'd49);
            16'heb26: r = filt_row(6'd50);
            16'hed28: r = filt_row(6'd51);
            16'hee29: r = filt_row(6'd52);
            16'he520: r = filt_row(6'd53);
            default:  r = '0;
        endcase
        return r;
    endfunction

    // step is -1, 0 or +1; result is step times accel
    function automatic logic signed [4:0] scale_step(input logic signed [1:0] step,
                                                     input logic [3:0] accel);
        logic signed [4:0] mag;
        mag = $signed({1'b0, accel});
        if (step == 2'sd0)
            return 5'sd0;
        else if (step < 2'sd0)
            return 5'sd0 - mag;
        else
            return mag;
    endfunction

endpackage

>>> rtl/core/remote_key_event_translator_top.sv
// Top level of the remote key event translator: stream ports, register port, pipeline.
//
// Input channel (s_*): one transaction per received remote-control packet with
// its timestamp. Output channel (m_*): key and motion events, one per
// transaction; m_tlast marks the final event of a packet.
// Register port: APB-style, one register (ticks_per_second at offset 0); the user
// must see that it is written only while the block is idle; the block does not enforce this.
//
// The first event of a packet passes the input register, then the result
// register, before it reaches the output. A packet gives zero, one or two
// events; throughput is one packet per cycle for packets with at most one
// event while the receiver does not stall. A two-event packet holds the
// result register until the single output port has drained both events.
// The input register is refilled while a result is still waiting, so the
// next packet is already held when the receiver takes the last event.
// Reset clears all valid flags, the key history and the change timestamp,
// and loads ticks_per_second with 100. When the receiver stalls, the current
// event holds on m_tdata/m_tuser/m_tlast and s_tready falls once the input
// register holds a packet that cannot move on.
module remote_key_event_translator_top #(
    parameter int TIME_BITS = rket_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] packet_length, [11:4] header_byte, [19:12] key_byte_a,
    // [27:20] key_byte_b, [35:28] trailer_byte, [67:36] time_now, [71:68] zero
    input  logic [71:0] s_tdata,
    // [0] transfer_error
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] event_code, [10:6] event_value, [15:11] zero
    output logic [15:0] m_tdata,
    // [0] event_kind
    output logic        m_tuser,
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0]          ticks_reg;
    logic [10:0]          ticks_next;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    rket_pkg::packet_t    in_pkt_reg;
    rket_pkg::packet_t    in_pkt_next;

    logic [7:0]           prev_a_reg;
    logic [7:0]           prev_a_next;
    logic [7:0]           prev_b_reg;
    logic [7:0]           prev_b_next;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] change_time_next;

    logic [1:0]           res_cnt_reg;
    logic [1:0]           res_cnt_next;
    logic                 res_sel_reg;
    logic                 res_sel_next;
    rket_pkg::event_t     res_ev0_reg;
    rket_pkg::event_t     res_ev0_next;
    rket_pkg::event_t     res_ev1_reg;
    rket_pkg::event_t     res_ev1_next;

    logic                 s_fire;
    logic                 m_fire;
    logic                 res_free;
    logic                 commit;
    logic [TIME_BITS-1:0] now;
    rket_pkg::xlate_res_t xr;
    rket_pkg::event_t     cur_ev;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == rket_pkg::REG_TICKS) ? {21'd0, ticks_reg} : 32'd0;

    always_comb
    begin
        ticks_next = ticks_reg;
        if (psel && penable && pwrite && (paddr == rket_pkg::REG_TICKS))
            ticks_next = pwdata[10:0];
    end

    // handshake and pipeline control
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign res_free = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_tready);
    assign commit   = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || commit;

    assign now = TIME_BITS'(in_pkt_reg.time_now);

    rket_xlate #(
        .TIME_BITS (TIME_BITS)
    ) u_xlate (
        .pkt         (in_pkt_reg),
        .now         (now),
        .prev_a      (prev_a_reg),
        .prev_b      (prev_b_reg),
        .change_time (change_time_reg),
        .ticks       (ticks_reg),
        .res         (xr)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_pkt_next   = in_pkt_reg;
        if (s_fire)
        begin
            in_valid_next              = 1'b1;
            in_pkt_next.transfer_error = s_tuser;
            in_pkt_next.packet_length  = s_tdata[3:0];
            in_pkt_next.header_byte    = s_tdata[11:4];
            in_pkt_next.key_byte_a     = s_tdata[19:12];
            in_pkt_next.key_byte_b     = s_tdata[27:20];
            in_pkt_next.trailer_byte   = s_tdata[35:28];
            in_pkt_next.time_now       = s_tdata[67:36];
        end
        else if (commit)
        begin
            in_valid_next = 1'b0;
        end
    end

    // key history, updated only by well-framed packets
    always_comb
    begin
        prev_a_next      = prev_a_reg;
        prev_b_next      = prev_b_reg;
        change_time_next = change_time_reg;
        if (commit && xr.frame_ok)
        begin
            prev_a_next = in_pkt_reg.key_byte_a;
            prev_b_next = in_pkt_reg.key_byte_b;
            if (!xr.same)
                change_time_next = now;
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res_sel_next = res_sel_reg;
        res_ev0_next = res_ev0_reg;
        res_ev1_next = res_ev1_reg;
        if (commit)
        begin
            res_cnt_next = xr.count;
            res_sel_next = 1'b0;
            res_ev0_next = xr.ev0;
            res_ev1_next = xr.ev1;
        end
        else if (m_fire)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res_sel_next = 1'b1;
        end
    end

    assign cur_ev   = res_sel_reg ? res_ev1_reg : res_ev0_reg;
    assign m_tvalid = (res_cnt_reg != 2'd0);
    assign m_tdata  = {5'd0, cur_ev.event_value, cur_ev.event_code};
    assign m_tuser  = cur_ev.event_kind;
    assign m_tlast  = cur_ev.last_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg       <= rket_pkg::TICKS_RESET;
            in_valid_reg    <= 1'b0;
            prev_a_reg      <= 8'd0;
            prev_b_reg      <= 8'd0;
            change_time_reg <= '0;
            res_cnt_reg     <= 2'd0;
            res_sel_reg     <= 1'b0;
        end
        else
        begin
            ticks_reg       <= ticks_next;
            in_valid_reg    <= in_valid_next;
            prev_a_reg      <= prev_a_next;
            prev_b_reg      <= prev_b_next;
            change_time_reg <= change_time_next;
            res_cnt_reg     <= res_cnt_next;
            res_sel_reg     <= res_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_pkt_reg  <= in_pkt_next;
        res_ev0_reg <= res_ev0_next;
        res_ev1_reg <= res_ev1_next;
    end

endmodule

>>> rtl/core/rket_xlate.sv
// Packet check, table match, acceleration and event generation for one packet.
module rket_xlate #(
    parameter int TIME_BITS = rket_pkg::TIME_BITS_DEF
) (
    input  rket_pkg::packet_t    pkt,
    input  logic [TIME_BITS-1:0] now,
    input  logic [7:0]           prev_a,
    input  logic [7:0]           prev_b,
    input  logic [TIME_BITS-1:0] change_time,
    input  logic [10:0]          ticks,
    output rket_pkg::xlate_res_t res
);

    logic [TIME_BITS-1:0] elapsed;
    logic [12:0]          thr4;
    logic [12:0]          thr3;
    logic [12:0]          thr2;
    logic [12:0]          thr1;
    logic [12:0]          thr_half;
    logic [12:0]          thr_quarter;
    logic                 same;
    logic [3:0]           accel;
    rket_pkg::row_info_t  ri;
    rket_pkg::event_t     ev0;
    rket_pkg::event_t     ev1;
    logic [1:0]           count;

    assign elapsed     = now - change_time;
    assign thr1        = {2'b00, ticks};
    assign thr2        = {1'b0, ticks, 1'b0};
    assign thr4        = {ticks, 2'b00};
    assign thr3        = thr1 + thr2;
    assign thr_half    = {3'b000, ticks[10:1]};
    assign thr_quarter = {4'b0000, ticks[10:2]};

    assign same = (prev_a == pkt.key_byte_a) && (prev_b == pkt.key_byte_b);
    assign ri   = rket_pkg::row_lookup({pkt.key_byte_a, pkt.key_byte_b});

    always_comb
    begin
        accel = 4'd1;
        if (same)
        begin
            if (elapsed > TIME_BITS'(thr4))
                accel = 4'd8;
            else if (elapsed > TIME_BITS'(thr3))
                accel = 4'd6;
            else if (elapsed > TIME_BITS'(thr2))
                accel = 4'd4;
            else if (elapsed > TIME_BITS'(thr1))
                accel = 4'd3;
            else if (elapsed > TIME_BITS'(thr_half))
                accel = 4'd2;
        end
    end

    always_comb
    begin
        ev0   = '0;
        ev1   = '0;
        count = 2'd0;
        if (ri.hit)
        begin
            case (ri.kind)
                rket_pkg::K_BUTTON:
                begin
                    ev0.event_kind  = rket_pkg::EV_KEY;
                    ev0.event_code  = ri.row;
                    ev0.event_value = 5'(ri.sx);
                    ev0.last_event  = 1'b1;
                    count           = 2'd1;
                end
                rket_pkg::K_MOVE:
                begin
                    ev0.event_kind = rket_pkg::EV_MOTION;
                    ev0.last_event = 1'b1;
                    if (ri.sx != 2'sd0)
                    begin
                        ev0.event_code  = rket_pkg::AXIS_X;
                        ev0.event_value = rket_pkg::scale_step(ri.sx, accel);
                    end
                    else
                    begin
                        ev0.event_code  = rket_pkg::AXIS_Y;
                        ev0.event_value = rket_pkg::scale_step(ri.sy, accel);
                    end
                    count = 2'd1;
                end
                rket_pkg::K_DIAG:
                begin
                    ev0.event_kind  = rket_pkg::EV_MOTION;
                    ev0.event_code  = rket_pkg::AXIS_X;
                    ev0.event_value = rket_pkg::scale_step(ri.sx, accel);
                    ev0.last_event  = 1'b0;
                    ev1.event_kind  = rket_pkg::EV_MOTION;
                    ev1.event_code  = rket_pkg::AXIS_Y;
                    ev1.event_value = rket_pkg::scale_step(ri.sy, accel);
                    ev1.last_event  = 1'b1;
                    count           = 2'd2;
                end
                default:
                begin
                    // filtered key: drop quick repeats, else press then release
                    if (!(same && (elapsed < TIME_BITS'(thr_quarter))))
                    begin
                        ev0.event_kind  = rket_pkg::EV_KEY;
                        ev0.event_code  = ri.row;
                        ev0.event_value = 5'sd1;
                        ev0.last_event  = 1'b0;
                        ev1.event_kind  = rket_pkg::EV_KEY;
                        ev1.event_code  = ri.row;
                        ev1.event_value = 5'sd0;
                        ev1.last_event  = 1'b1;
                        count           = 2'd2;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.frame_ok = !pkt.transfer_error
                       && (pkt.packet_length == rket_pkg::PACKET_LEN)
                       && (pkt.header_byte == rket_pkg::HEADER_CODE)
                       && (pkt.trailer_byte == rket_pkg::TRAILER_CODE);
        res.same  = same;
        res.count = res.frame_ok ? count : 2'd0;
        res.ev0   = ev0;
        res.ev1   = ev1;
    end

endmodule
